>>> rtl/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion block.
`timescale 1ns / 1ps

package rmq_pkg;

    // Default number of fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 14;

    // Width of one matrix entry and of one signed output part
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int QW_W  = 15;

    // Quotient bits of each division (|n|/S never exceeds 2)
    localparam int QUO_W = 16;

    // Numerator width: sum or difference of two entries
    localparam int NUM_W = IN_W + 1;

    // Stream widths
    localparam int S_DATA_W = 9 * IN_W;
    localparam int M_DATA_W = 64;

    // Branch that owns the S/4 part
    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z,
        SEL_W
    } sel_t;

endpackage

>>> rtl/rotation_matrix_to_quaternion.sv
// Pipelined rotation matrix to unit quaternion converter.
`timescale 1ns / 1ps
//
// Input stream s_*: one beat carries the nine Q1.14 entries of a 3x3 rotation
// block. Output stream m_*: one beat carries the quaternion (qx, qy, qz, qw),
// with w made non-negative and every part saturated to plus or minus one.
// Throughput is one beat per cycle while the skid register is empty. From input
// handshake to m_tvalid the path holds, SW being the root width (SW = 17 at
// 14 fraction bits): one prepare stage, one stage per root bit of the square
// root, one dividend stage, one stage per quotient bit (16) of the three
// parallel dividers, and the output register.
// The root and quotient bit counts set that depth.
// Reset clears every valid bit; the pipeline comes up empty and ready.
// The whole pipeline advances as one. A result that waits on a stalled
// receiver sits in the output register while the pipeline keeps moving; a
// second waiting result goes to a skid register, and only then does s_tready
// drop until the receiver takes a beat.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // qx[15:0], qy[31:16], qz[47:32], qw[62:48], zero pad [63]
    output logic [M_DATA_W-1:0] m_tdata
);

    // Derived widths
    localparam int AW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;   // sqrt argument
    localparam int VW  = AW + FRAC_BITS + 2;                          // radicand
    localparam int SW  = (VW + 1) / 2;                                // root
    localparam int VW2 = 2 * SW;
    localparam int DW  = (((NUM_W + FRAC_BITS) > SW) ? (NUM_W + FRAC_BITS) : SW) + 1;
    localparam int CW  = (DW > (SW + QUO_W)) ? DW : (SW + QUO_W);   // divider remainder
    localparam int RW  = ((QUO_W > SW) ? QUO_W : SW) + 2;            // result math
    localparam logic signed [AW:0]   ONE_A = (AW + 1)'(64'd1 << FRAC_BITS);
    localparam logic signed [RW-1:0] ONE_R = RW'(64'd1 << FRAC_BITS);

    typedef struct packed {
        sel_t                    sel;
        logic signed [NUM_W-1:0] n0;
        logic signed [NUM_W-1:0] n1;
        logic signed [NUM_W-1:0] n2;
    } ctx_t;

    typedef struct packed {
        ctx_t          ctx;
        logic [AW-1:0] arg;
        logic [SW-1:0] root;
        logic [SW:0]   rem;
    } sq_t;

    typedef struct packed {
        sel_t             sel;
        logic             neg0;
        logic             neg1;
        logic             neg2;
        logic [SW-1:0]    s;
        logic [CW-1:0]    r0;
        logic [CW-1:0]    r1;
        logic [CW-1:0]    r2;
        logic [QUO_W-1:0] q0;
        logic [QUO_W-1:0] q1;
        logic [QUO_W-1:0] q2;
    } dv_t;

    sq_t  sq_reg  [0:SW];
    logic sq_vld_reg [0:SW];
    dv_t  dv_reg  [0:QUO_W];
    logic dv_vld_reg [0:QUO_W];

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                skid_valid_reg;
    logic [M_DATA_W-1:0] skid_data_reg;

    logic en;
    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    // Prepare: trace, branch select, sqrt argument, numerators
    logic signed [IN_W-1:0]  m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [IN_W+1:0]  tr;
    logic signed [AW:0]      arg_s;
    logic signed [NUM_W-1:0] dx, dy, dz, sxy, sxz, syz;
    sq_t                     prep;

    always_comb
    begin
        m00 = s_tdata[0*IN_W +: IN_W];
        m01 = s_tdata[1*IN_W +: IN_W];
        m02 = s_tdata[2*IN_W +: IN_W];
        m10 = s_tdata[3*IN_W +: IN_W];
        m11 = s_tdata[4*IN_W +: IN_W];
        m12 = s_tdata[5*IN_W +: IN_W];
        m20 = s_tdata[6*IN_W +: IN_W];
        m21 = s_tdata[7*IN_W +: IN_W];
        m22 = s_tdata[8*IN_W +: IN_W];
        tr  = (IN_W + 2)'(m00) + (IN_W + 2)'(m11) + (IN_W + 2)'(m22);
        dx  = NUM_W'(m21) - NUM_W'(m12);
        dy  = NUM_W'(m02) - NUM_W'(m20);
        dz  = NUM_W'(m10) - NUM_W'(m01);
        sxy = NUM_W'(m01) + NUM_W'(m10);
        sxz = NUM_W'(m02) + NUM_W'(m20);
        syz = NUM_W'(m12) + NUM_W'(m21);
        prep      = '0;
        if (tr > 0)
        begin
            prep.ctx.sel = SEL_W;
            arg_s        = ONE_A + (AW + 1)'(tr);
            prep.ctx.n0  = dx;
            prep.ctx.n1  = dy;
            prep.ctx.n2  = dz;
        end
        else if (m00 > m11 && m00 > m22)
        begin
            prep.ctx.sel = SEL_X;
            arg_s        = ONE_A + (AW + 1)'(m00) - (AW + 1)'(m11) - (AW + 1)'(m22);
            prep.ctx.n0  = dx;
            prep.ctx.n1  = sxy;
            prep.ctx.n2  = sxz;
        end
        else if (m11 > m22)
        begin
            prep.ctx.sel = SEL_Y;
            arg_s        = ONE_A + (AW + 1)'(m11) - (AW + 1)'(m00) - (AW + 1)'(m22);
            prep.ctx.n0  = dy;
            prep.ctx.n1  = sxy;
            prep.ctx.n2  = syz;
        end
        else
        begin
            prep.ctx.sel = SEL_Z;
            arg_s        = ONE_A + (AW + 1)'(m22) - (AW + 1)'(m00) - (AW + 1)'(m11);
            prep.ctx.n0  = dz;
            prep.ctx.n1  = sxz;
            prep.ctx.n2  = syz;
        end
        // branch rules keep the argument at or above one
        prep.arg = arg_s[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= prep;
        end
    end

    // Square root: one root bit per stage
    genvar j;
    generate
        for (j = 0; j < SW; j++)
        begin : g_sqrt
            logic [VW2-1:0] vfull;
            logic [SW+2:0]  rem_sh;
            logic [SW+2:0]  trial;
            sq_t            nxt;

            always_comb
            begin
                vfull  = VW2'(sq_reg[j].arg) << (FRAC_BITS + 2);
                rem_sh = {sq_reg[j].rem, vfull[2*(SW-1-j)+1 -: 2]};
                trial  = (SW + 3)'({sq_reg[j].root, 2'b01});
                nxt    = sq_reg[j];
                if (rem_sh >= trial)
                begin
                    nxt.rem  = rem_sh[SW:0] - trial[SW:0];
                    nxt.root = {sq_reg[j].root[SW-2:0], 1'b1};
                end
                else
                begin
                    nxt.rem  = rem_sh[SW:0];
                    nxt.root = {sq_reg[j].root[SW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_vld_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    sq_vld_reg[j+1] <= sq_vld_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_reg[j+1] <= nxt;
                end
            end
        end
    endgenerate

    // Dividend: |n| * 2^FRAC_BITS + S/2 for each lane
    logic [NUM_W-1:0] mag0, mag1, mag2;
    logic [SW-1:0]    s_root;
    dv_t              dv_first;

    always_comb
    begin
        s_root = sq_reg[SW].root;
        mag0   = sq_reg[SW].ctx.n0[NUM_W-1] ? NUM_W'(~sq_reg[SW].ctx.n0 + 1'b1)
                                             : NUM_W'(sq_reg[SW].ctx.n0);
        mag1   = sq_reg[SW].ctx.n1[NUM_W-1] ? NUM_W'(~sq_reg[SW].ctx.n1 + 1'b1)
                                             : NUM_W'(sq_reg[SW].ctx.n1);
        mag2   = sq_reg[SW].ctx.n2[NUM_W-1] ? NUM_W'(~sq_reg[SW].ctx.n2 + 1'b1)
                                             : NUM_W'(sq_reg[SW].ctx.n2);
        dv_first.sel  = sq_reg[SW].ctx.sel;
        dv_first.neg0 = sq_reg[SW].ctx.n0[NUM_W-1];
        dv_first.neg1 = sq_reg[SW].ctx.n1[NUM_W-1];
        dv_first.neg2 = sq_reg[SW].ctx.n2[NUM_W-1];
        dv_first.s    = s_root;
        dv_first.r0   = (CW'(mag0) << FRAC_BITS) + CW'(s_root >> 1);
        dv_first.r1   = (CW'(mag1) << FRAC_BITS) + CW'(s_root >> 1);
        dv_first.r2   = (CW'(mag2) << FRAC_BITS) + CW'(s_root >> 1);
        dv_first.q0   = '0;
        dv_first.q1   = '0;
        dv_first.q2   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_vld_reg[0] <= sq_vld_reg[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= dv_first;
        end
    end

    // Restoring division: one quotient bit per stage, three lanes
    genvar i;
    generate
        for (i = 0; i < QUO_W; i++)
        begin : g_div
            localparam int B = QUO_W - 1 - i;
            logic [CW-1:0] dsh;
            dv_t           nxt;

            always_comb
            begin
                dsh = CW'(dv_reg[i].s) << B;
                nxt = dv_reg[i];
                if (dv_reg[i].r0 >= dsh)
                begin
                    nxt.r0    = dv_reg[i].r0 - dsh;
                    nxt.q0[B] = 1'b1;
                end
                if (dv_reg[i].r1 >= dsh)
                begin
                    nxt.r1    = dv_reg[i].r1 - dsh;
                    nxt.q1[B] = 1'b1;
                end
                if (dv_reg[i].r2 >= dsh)
                begin
                    nxt.r2    = dv_reg[i].r2 - dsh;
                    nxt.q2[B] = 1'b1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_vld_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    dv_vld_reg[i+1] <= dv_vld_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_reg[i+1] <= nxt;
                end
            end
        end
    endgenerate

    // Final: quarter, lane steering, sign fix on w, saturation
    dv_t                dl;
    logic [SW:0]        s_p2;
    logic signed [RW-1:0] quarter, l0, l1, l2;
    logic signed [RW-1:0] x, y, z, w;
    logic [M_DATA_W-1:0]  res_data;

    always_comb
    begin
        dl      = dv_reg[QUO_W];
        s_p2    = {1'b0, dl.s} + (SW + 1)'(2);
        quarter = $signed(RW'(s_p2 >> 2));
        l0      = dl.neg0 ? -$signed(RW'(dl.q0)) : $signed(RW'(dl.q0));
        l1      = dl.neg1 ? -$signed(RW'(dl.q1)) : $signed(RW'(dl.q1));
        l2      = dl.neg2 ? -$signed(RW'(dl.q2)) : $signed(RW'(dl.q2));
        case (dl.sel)
            SEL_W:
            begin
                x = l0; y = l1; z = l2; w = quarter;
            end
            SEL_X:
            begin
                w = l0; x = quarter; y = l1; z = l2;
            end
            SEL_Y:
            begin
                w = l0; x = l1; y = quarter; z = l2;
            end
            default:
            begin
                w = l0; x = l1; y = l2; z = quarter;
            end
        endcase
        if (w < 0)
        begin
            x = -x;
            y = -y;
            z = -z;
            w = -w;
        end
        if (x > ONE_R)       x = ONE_R;
        else if (x < -ONE_R) x = -ONE_R;
        if (y > ONE_R)       y = ONE_R;
        else if (y < -ONE_R) y = -ONE_R;
        if (z > ONE_R)       z = ONE_R;
        else if (z < -ONE_R) z = -ONE_R;
        if (w > ONE_R)       w = ONE_R;
        res_data = {1'b0, w[QW_W-1:0], z[OUT_W-1:0], y[OUT_W-1:0], x[OUT_W-1:0]};
    end

    // Output register plus skid register
    logic push, pop;
    assign push = en & dv_vld_reg[QUO_W];
    assign pop  = out_valid_reg & m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= res_data;
            end
            else
            begin
                skid_data_reg <= res_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion block, with bind.
`timescale 1ns / 1ps

module rmq_checker
    import rmq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    localparam logic signed [OUT_W-1:0] ONE_O = OUT_W'(1 << FRAC_BITS_DEF);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // Input side only backs up after the output has stalled
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("s_tready dropped without an output stall");

    // Back-pressure only while a result is waiting
    a_ready_wait: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result waiting");

    // w is saturated and non-negative
    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[62:48] <= 15'(ONE_O) && !m_tdata[63])
        else $error("qw out of range");

    // x saturated to plus or minus one
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[15:0]) <= ONE_O && $signed(m_tdata[15:0]) >= -ONE_O)
        else $error("qx out of range");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> dv/tb.sv
// Self-checking testbench for the rotation matrix to quaternion converter.
`timescale 1ns / 1ps

module tb;
    import rmq_pkg::*;

    typedef struct packed {
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        logic [14:0] qw;
    } quat_t;

    localparam int ONE       = 1 << FRAC_BITS_DEF;
    localparam int N_RANDOM  = 450;
    localparam int LATENCY   = FRAC_BITS_DEF + 22;
    localparam int N_DIRECTED = 12;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    quat_t quat_fifo[$];
    int    n_errors;
    int    n_beats_out;
    int    n_beats_in;
    int    n_branch[4];
    bit    stim_done;
    bit    hold_off;

    rotation_matrix_to_quaternion uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("Timeout");
        $display("Some tests failed");
        $finish;
    end

    // Integer square root, bitwise
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // n * ONE / s, rounded to nearest, ties away from zero
    function automatic longint div_round(longint n, longint s);
        longint unsigned mag;
        longint unsigned q;
        if (s <= 0) return 0;
        mag = (n < 0 ? -n : n) << FRAC_BITS_DEF;
        q   = (mag + s / 2) / s;
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic sel_t pick_branch(logic [S_DATA_W-1:0] d);
        longint m00, m11, m22;
        m00 = longint'($signed(d[0*16 +: 16]));
        m11 = longint'($signed(d[4*16 +: 16]));
        m22 = longint'($signed(d[8*16 +: 16]));
        if (m00 + m11 + m22 > 0) return SEL_W;
        if (m00 > m11 && m00 > m22) return SEL_X;
        if (m11 > m22) return SEL_Y;
        return SEL_Z;
    endfunction

    // Expected quaternion of one matrix
    function automatic quat_t matrix_to_quat(logic [S_DATA_W-1:0] d);
        longint m[9];
        longint a, s, quarter, x, y, z, w;
        sel_t   br;
        quat_t  q;
        for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[i*16 +: 16]));
        br = pick_branch(d);
        case (br)
            SEL_W:   a = ONE + m[0] + m[4] + m[8];
            SEL_X:   a = ONE + m[0] - m[4] - m[8];
            SEL_Y:   a = ONE + m[4] - m[0] - m[8];
            default: a = ONE + m[8] - m[0] - m[4];
        endcase
        if (a < 0) a = 0;
        s       = longint'(int_sqrt(longint'(a) << (FRAC_BITS_DEF + 2)));
        quarter = (s + 2) >>> 2;
        case (br)
            SEL_W:
            begin
                w = quarter;
                x = div_round(m[7] - m[5], s);
                y = div_round(m[2] - m[6], s);
                z = div_round(m[3] - m[1], s);
            end
            SEL_X:
            begin
                w = div_round(m[7] - m[5], s);
                x = quarter;
                y = div_round(m[1] + m[3], s);
                z = div_round(m[2] + m[6], s);
            end
            SEL_Y:
            begin
                w = div_round(m[2] - m[6], s);
                x = div_round(m[1] + m[3], s);
                y = quarter;
                z = div_round(m[5] + m[7], s);
            end
            default:
            begin
                w = div_round(m[3] - m[1], s);
                x = div_round(m[2] + m[6], s);
                y = div_round(m[5] + m[7], s);
                z = quarter;
            end
        endcase
        if (w < 0)
        begin
            x = -x;
            y = -y;
            z = -z;
            w = -w;
        end
        q.qx = 16'(sat(x, -ONE, ONE));
        q.qy = 16'(sat(y, -ONE, ONE));
        q.qz = 16'(sat(z, -ONE, ONE));
        q.qw = 15'(sat(w, 0, ONE));
        return q;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR beat %0d: %s got %0d expected %0d", n_beats_out, what, got, want);
        n_errors++;
    endtask

    function automatic logic [S_DATA_W-1:0] pack_matrix(int e[9]);
        logic [S_DATA_W-1:0] d;
        for (int i = 0; i < 9; i++) d[i*16 +: 16] = 16'(e[i]);
        return d;
    endfunction

    // Random entry, mostly inside the Q1.14 range, sometimes any 16-bit value
    function automatic int rand_entry();
        if ($urandom_range(0, 9) == 0) return int'($signed(16'($urandom())));
        return $urandom_range(0, 2 * ONE) - ONE;
    endfunction

    // Roughly orthonormal matrix: rotation about a random axis by a random angle
    // in [0, 2*pi), entries rounded to Q1.14 and clamped to plus or minus one
    function automatic logic [S_DATA_W-1:0] rand_rotation();
        real ang, ux, uy, uz, n, c, sn, t, r[9];
        int  e[9];
        ux  = $urandom_range(0, 2000) - 1000.0;
        uy  = $urandom_range(0, 2000) - 1000.0;
        uz  = $urandom_range(0, 2000) - 1000.0;
        n   = $sqrt(ux * ux + uy * uy + uz * uz) + 1e-9;
        ux /= n; uy /= n; uz /= n;
        ang = $urandom_range(0, 62832) / 10000.0;
        c = $cos(ang); sn = $sin(ang); t = 1.0 - c;
        r[0] = c + ux * ux * t;      r[1] = ux * uy * t - uz * sn; r[2] = ux * uz * t + uy * sn;
        r[3] = uy * ux * t + uz * sn; r[4] = c + uy * uy * t;      r[5] = uy * uz * t - ux * sn;
        r[6] = uz * ux * t - uy * sn; r[7] = uz * uy * t + ux * sn; r[8] = c + uz * uz * t;
        for (int i = 0; i < 9; i++)
        begin
            e[i] = int'(r[i] * ONE);
            if (e[i] > ONE)  e[i] = ONE;
            if (e[i] < -ONE) e[i] = -ONE;
        end
        return pack_matrix(e);
    endfunction

    // Directed rows: entries m00..m22, expected result where obvious
    typedef struct {
        int    e[9];
        bit    known;
        quat_t want;
    } row_t;
    row_t rows[N_DIRECTED];

    initial
    begin
        // identity
        rows[0]  = '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1, '{16'd0, 16'd0, 16'd0, 15'(ONE)}};
        // 180 degrees about x, y and z: each diagonal branch
        rows[1]  = '{'{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1, '{16'(ONE), 16'd0, 16'd0, 15'd0}};
        rows[2]  = '{'{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}, 1, '{16'd0, 16'(ONE), 16'd0, 15'd0}};
        rows[3]  = '{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}, 1, '{16'd0, 16'd0, 16'(ONE), 15'd0}};
        // all zero: trace zero, ties fall to the m22 branch, z = sqrt(1)/2
        rows[4]  = '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{16'd0, 16'd0, 16'(ONE / 2), 15'd0}};
        // 90 degrees about z, then about x
        rows[5]  = '{'{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE}, 0, '0};
        rows[6]  = '{'{ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0}, 0, '0};
        // negative w in a diagonal branch forces negation
        rows[7]  = '{'{ONE, 0, 0, 0, -ONE, ONE, 0, -ONE, -ONE}, 0, '0};
        // extremes of the 16-bit fields, saturation paths
        rows[8]  = '{'{32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767}, 0, '0};
        rows[9]  = '{'{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768}, 0, '0};
        rows[10] = '{'{-ONE, ONE, ONE, ONE, -ONE, ONE, ONE, ONE, -ONE}, 0, '0};
        rows[11] = '{'{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 0, '0};
    end

    task automatic send_beat(logic [S_DATA_W-1:0] d);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        quat_fifo.push_back(matrix_to_quat(d));
        n_branch[pick_branch(d)]++;
        n_beats_in++;
        @(negedge clk);
    endtask

    // Sender
    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        rst_n     = 1'b0;
        n_errors  = 0;
        stim_done = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_beat(pack_matrix(rows[i].e));
            if (rows[i].known) quat_fifo[$] = rows[i].want;
        end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                send_beat(rand_rotation());
            else
            begin
                int e[9];
                for (int k = 0; k < 9; k++) e[k] = rand_entry();
                send_beat(pack_matrix(e));
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    // Long receiver stall partway through, so the pipeline backs up
    initial
    begin
        hold_off = 0;
        wait (n_beats_in == 150);
        @(negedge clk);
        hold_off = 1;
        repeat (3 * LATENCY) @(negedge clk);
        hold_off = 0;
    end

    // Receiver ready
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if (m_tready && !(m_tvalid && $urandom_range(0, 1) == 0))
                m_tready <= 1'b1;
            else
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                if (gap == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                    m_tready <= !hold_off;
                end
            end
        end
    end

    // Output checker
    always @(posedge clk)
    begin
        quat_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.qx = m_tdata[15:0];
            got.qy = m_tdata[31:16];
            got.qz = m_tdata[47:32];
            got.qw = m_tdata[62:48];
            if (quat_fifo.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                want = quat_fifo.pop_front();
                if (got.qx !== want.qx)
                    report_mismatch("qx", $signed(got.qx), $signed(want.qx));
                if (got.qy !== want.qy)
                    report_mismatch("qy", $signed(got.qy), $signed(want.qy));
                if (got.qz !== want.qz)
                    report_mismatch("qz", $signed(got.qz), $signed(want.qz));
                if (got.qw !== want.qw)
                    report_mismatch("qw", got.qw, want.qw);
                if (m_tdata[63] !== 1'b0)
                    report_mismatch("pad bit", m_tdata[63], 0);
            end
            n_beats_out++;
        end
    end

    // End of run
    initial
    begin
        n_beats_out = 0;
        n_beats_in  = 0;
        wait (stim_done);
        wait (quat_fifo.size() == 0);
        repeat (2 * LATENCY) @(posedge clk);
        $display("Checked %0d quaternions from %0d matrices", n_beats_out, n_beats_in);
        $display("Branches: trace %0d, m00 %0d, m11 %0d, m22 %0d",
                 n_branch[SEL_W], n_branch[SEL_X], n_branch[SEL_Y], n_branch[SEL_Z]);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/rmq_pkg.sv
rtl/rotation_matrix_to_quaternion.sv
rtl/rmq_checker.sv
dv/tb.sv
